/* hdl/gcre_pkg.sv */
// ----------------------------------------------------------------------------
// gcre_pkg
// Shared types and constants of the glyph crop run-length encoder.
// ----------------------------------------------------------------------------
package gcre_pkg;

    localparam int MAX_CELL_W = 8;
    localparam int MAX_CELL_H = 8;

    localparam int SIZE_W   = 4;
    localparam int PIXEL_W  = 8;
    localparam int ADDR_W   = 6;
    localparam int RUN_W    = 5;
    localparam int CODE_W   = 8;
    localparam int QDEPTH   = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [RUN_W-1:0] RUN_LIMIT  = 5'h1f;
    localparam logic [2:0]       COLOR_BITS = 3'b001;

    localparam logic REG_CELL_WIDTH  = 1'b0;
    localparam logic REG_CELL_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0] x_offset;
        logic [SIZE_W-1:0] y_offset;
        logic [SIZE_W-1:0] box_width;
        logic [SIZE_W-1:0] box_height;
        logic [CODE_W-1:0] code;
        logic              code_valid;
        logic              last_code;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* hdl/gcre_ram.sv */
// ----------------------------------------------------------------------------
// gcre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/gcre_fifo.sv */
// ----------------------------------------------------------------------------
// gcre_fifo
// Small register FIFO; head entry shown while not empty.
// ----------------------------------------------------------------------------
module gcre_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gcre_pkg::t_q_ctrl      i_ctrl,
    input  logic [WIDTH-1:0]       i_data,
    output gcre_pkg::t_q_stat      o_stat,
    output logic [WIDTH-1:0]       o_data
);
    import gcre_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr, rd;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign wr = i_ctrl.push && !o_stat.full;
    assign rd = i_ctrl.pop && !o_stat.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (wr && !rd) begin
            n_count = r_count + CW'(1);
        end else if (rd && !wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/gcre_front.sv */
// ----------------------------------------------------------------------------
// gcre_front
// Input side: tracks the load position and turns each pixel into a
// store command for the back end.
// ----------------------------------------------------------------------------
module gcre_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gcre_pkg::t_cfg                  i_cfg,
    input  logic                            i_accept,
    input  logic [gcre_pkg::PIXEL_W-1:0]    i_pixel,
    input  logic                            i_last_pixel,
    output gcre_pkg::t_cmd                  o_cmd
);
    import gcre_pkg::*;

    localparam int NW = 2 * SIZE_W;

    logic [ADDR_W-1:0] r_lp, n_lp;
    logic [NW-1:0]     cells;
    logic [NW-1:0]     lp_ext;
    logic              in_cell;

    assign cells   = NW'(i_cfg.w) * NW'(i_cfg.h);
    assign lp_ext  = NW'(r_lp);
    assign in_cell = (lp_ext < cells);

    assign o_cmd.we    = in_cell;
    assign o_cmd.addr  = r_lp;
    assign o_cmd.pixel = i_pixel;
    assign o_cmd.last  = i_last_pixel;

    always_comb begin
        n_lp = r_lp;
        if (i_accept) begin
            if (i_last_pixel) begin
                n_lp = '0;
            end else if (lp_ext < cells - NW'(1)) begin
                n_lp = r_lp + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else begin
            r_lp <= n_lp;
        end
    end

endmodule

/* hdl/gcre_back.sv */
// ----------------------------------------------------------------------------
// gcre_back
// Execution side: stores pixels, scans the cell for its bounding box,
// then scans the box and emits run-length codes.
// ----------------------------------------------------------------------------
module gcre_back #(
    parameter int MAX_CELL_W = gcre_pkg::MAX_CELL_W,
    parameter int MAX_CELL_H = gcre_pkg::MAX_CELL_H
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gcre_pkg::t_cfg      i_cfg,
    input  gcre_pkg::t_cmd      i_cmd,
    input  gcre_pkg::t_q_stat   i_cmd_stat,
    output logic                o_cmd_pop,
    input  gcre_pkg::t_q_stat   i_res_stat,
    output logic                o_res_push,
    output gcre_pkg::t_result   o_res
);
    import gcre_pkg::*;

    localparam int DEPTH = MAX_CELL_W * MAX_CELL_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = 2 * SIZE_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_BOX_RD  = 6'b000010,
        S_BOX_EV  = 6'b000100,
        S_EMIT_RD = 6'b001000,
        S_EMIT_EV = 6'b010000,
        S_BLANK   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_row, n_row, r_col, n_col;
    logic [SIZE_W-1:0]   r_left, n_left, r_right, n_right;
    logic [SIZE_W-1:0]   r_top, n_top, r_bot, n_bot;
    logic [SIZE_W-1:0]   r_lrow, n_lrow, r_lcol, n_lcol;
    logic                r_found, n_found;
    logic [RUN_W-1:0]    r_run, n_run;

    logic                rd_en;
    logic [LW-1:0]       lin;
    logic [PIXEL_W-1:0]  rd_data;
    logic                nz;
    logic [RUN_W-1:0]    run_inc;

    assign lin     = LW'(r_row) * LW'(i_cfg.w) + LW'(r_col);
    assign nz      = (rd_data != '0);
    assign run_inc = r_run + RUN_W'(1);

    gcre_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (o_cmd_pop && i_cmd.we),
        .i_wr_addr (i_cmd.addr[AW-1:0]),
        .i_wr_data (i_cmd.pixel),
        .i_rd_en   (rd_en),
        .i_rd_addr (lin[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_left     = r_left;
        n_right    = r_right;
        n_top      = r_top;
        n_bot      = r_bot;
        n_lrow     = r_lrow;
        n_lcol     = r_lcol;
        n_found    = r_found;
        n_run      = r_run;
        rd_en      = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        o_res.x_offset   = r_left;
        o_res.y_offset   = r_top;
        o_res.box_width  = r_right - r_left + SIZE_W'(1);
        o_res.box_height = r_bot - r_top + SIZE_W'(1);
        o_res.code       = {r_run, COLOR_BITS};
        o_res.code_valid = 1'b1;
        o_res.last_code  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_stat.empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.last) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_found = 1'b0;
                        n_left  = i_cfg.w;
                        n_right = '0;
                        n_top   = i_cfg.h;
                        n_bot   = '0;
                        n_state = S_BOX_RD;
                    end
                end
            end
            S_BOX_RD: begin
                rd_en   = 1'b1;
                n_state = S_BOX_EV;
            end
            S_BOX_EV: begin
                if (nz) begin
                    n_found = 1'b1;
                    n_lrow  = r_row;
                    n_lcol  = r_col;
                    n_bot   = r_row;
                    if (r_col < r_left) n_left = r_col;
                    if (r_col > r_right) n_right = r_col;
                    if (r_row < r_top) n_top = r_row;
                end
                n_state = S_BOX_RD;
                if (r_col == i_cfg.w - SIZE_W'(1)) begin
                    n_col = '0;
                    if (r_row == i_cfg.h - SIZE_W'(1)) begin
                        if (n_found) begin
                            n_row   = n_top;
                            n_col   = n_left;
                            n_run   = '0;
                            n_state = S_EMIT_RD;
                        end else begin
                            n_state = S_BLANK;
                        end
                    end else begin
                        n_row = r_row + SIZE_W'(1);
                    end
                end else begin
                    n_col = r_col + SIZE_W'(1);
                end
            end
            S_EMIT_RD: begin
                rd_en   = 1'b1;
                n_state = S_EMIT_EV;
            end
            S_EMIT_EV: begin
                if (nz) begin
                    o_res.last_code = (r_row == r_lrow) && (r_col == r_lcol);
                end else begin
                    o_res.code = {run_inc, COLOR_BITS};
                end
                if (nz || (run_inc == RUN_LIMIT)) begin
                    if (!i_res_stat.full) begin
                        o_res_push = 1'b1;
                        n_run      = '0;
                    end
                end else begin
                    n_run = run_inc;
                end
                if (!(nz || (run_inc == RUN_LIMIT)) || !i_res_stat.full) begin
                    if (nz && o_res.last_code) begin
                        n_run   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                        if (r_col == r_right) begin
                            n_col = r_left;
                            n_row = r_row + SIZE_W'(1);
                        end else begin
                            n_col = r_col + SIZE_W'(1);
                        end
                    end
                end
            end
            S_BLANK: begin
                o_res.x_offset   = '0;
                o_res.y_offset   = '0;
                o_res.box_width  = '0;
                o_res.box_height = '0;
                o_res.code       = '0;
                o_res.code_valid = 1'b0;
                o_res.last_code  = 1'b1;
                if (!i_res_stat.full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_left  <= n_left;
        r_right <= n_right;
        r_top   <= n_top;
        r_bot   <= n_bot;
        r_lrow  <= n_lrow;
        r_lcol  <= n_lcol;
    end

endmodule

/* hdl/glyph_crop_run_length_encoder_unit.sv */
// ----------------------------------------------------------------------------
// glyph_crop_run_length_encoder_unit
// Crops a glyph cell to the bounding box of its non-zero pixels and
// run-length encodes the transparent pixels inside that box.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle into a four-entry load queue while it is not
// full; while idle, the back end writes them to the cell RAM at one per cycle
// while the queue holds any. After the last pixel of a cell the back end
// scans the whole cell for its box, reading each cell pixel and then
// evaluating it through the registered RAM port, then scans the box up to its
// last non-zero pixel the same way, stalling while a code is due and the
// result queue is full. Pixels of the next cell fill the load queue meanwhile.
// A blank cell yields one result with code_valid low.
// ----------------------------------------------------------------------------
module glyph_crop_run_length_encoder_unit #(
    parameter int MAX_CELL_W = gcre_pkg::MAX_CELL_W,
    parameter int MAX_CELL_H = gcre_pkg::MAX_CELL_H
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gcre_pkg::APB_AW-1:0]     paddr,
    input  logic [gcre_pkg::APB_DW-1:0]     pwdata,
    output logic [gcre_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic [gcre_pkg::PIXEL_W-1:0]    i_pixel,
    input  logic                            i_last_pixel,
    output logic                            empty,
    input  logic                            pop,
    output logic [gcre_pkg::SIZE_W-1:0]     o_x_offset,
    output logic [gcre_pkg::SIZE_W-1:0]     o_y_offset,
    output logic [gcre_pkg::SIZE_W-1:0]     o_box_width,
    output logic [gcre_pkg::SIZE_W-1:0]     o_box_height,
    output logic [gcre_pkg::CODE_W-1:0]     o_code,
    output logic                            o_code_valid,
    output logic                            o_last_code
);
    import gcre_pkg::*;

    localparam logic [SIZE_W-1:0] W_MAX = SIZE_W'(MAX_CELL_W);
    localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(MAX_CELL_H);
    localparam logic [SIZE_W-1:0] W_RST = (MAX_CELL_W < 8) ? W_MAX : SIZE_W'(8);
    localparam logic [SIZE_W-1:0] H_RST = (MAX_CELL_H < 8) ? H_MAX : SIZE_W'(8);

    t_cfg              r_cfg, n_cfg;
    logic              cfg_wr;
    logic [SIZE_W-1:0] wr_val;
    logic [SIZE_W-1:0] w_clamped, h_clamped;

    t_cmd              front_cmd, q_cmd;
    t_q_ctrl           cmd_ctrl, res_ctrl;
    t_q_stat           cmd_stat, res_stat;
    logic              cmd_pop, res_push;
    t_result           back_res, q_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_val = pwdata[SIZE_W-1:0];

    assign w_clamped = (wr_val == '0) ? SIZE_W'(1) : ((wr_val > W_MAX) ? W_MAX : wr_val);
    assign h_clamped = (wr_val == '0) ? SIZE_W'(1) : ((wr_val > H_MAX) ? H_MAX : wr_val);

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_CELL_WIDTH:  n_cfg.w = w_clamped;
                REG_CELL_HEIGHT: n_cfg.h = h_clamped;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.w <= W_RST;
            r_cfg.h <= H_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign prdata = (paddr[2] == REG_CELL_HEIGHT) ? APB_DW'(r_cfg.h) : APB_DW'(r_cfg.w);

    gcre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (push && !full),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .o_cmd        (front_cmd)
    );

    assign cmd_ctrl.push = push;
    assign cmd_ctrl.pop  = cmd_pop;

    gcre_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QDEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cmd_ctrl),
        .i_data  (front_cmd),
        .o_stat  (cmd_stat),
        .o_data  (q_cmd)
    );

    assign full = cmd_stat.full;

    gcre_back #(
        .MAX_CELL_W (MAX_CELL_W),
        .MAX_CELL_H (MAX_CELL_H)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (q_cmd),
        .i_cmd_stat (cmd_stat),
        .o_cmd_pop  (cmd_pop),
        .i_res_stat (res_stat),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    assign res_ctrl.push = res_push;
    assign res_ctrl.pop  = pop;

    gcre_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QDEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (res_ctrl),
        .i_data  (back_res),
        .o_stat  (res_stat),
        .o_data  (q_res)
    );

    assign empty        = res_stat.empty;
    assign o_x_offset   = q_res.x_offset;
    assign o_y_offset   = q_res.y_offset;
    assign o_box_width  = q_res.box_width;
    assign o_box_height = q_res.box_height;
    assign o_code       = q_res.code;
    assign o_code_valid = q_res.code_valid;
    assign o_last_code  = q_res.last_code;

endmodule
